>>> rtl/core/prime_stepper_trial_division_assert.svh
// Assertion macros used by the checker file.
`ifndef PRIME_STEPPER_TRIAL_DIVISION_ASSERT_SVH
`define PRIME_STEPPER_TRIAL_DIVISION_ASSERT_SVH

// Same-cycle implication.
`define PST_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PST_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pst_pkg.sv
package pst_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 16;
   localparam int FIELD_WIDTH         = 16;
   localparam int ACTION_WIDTH        = 2;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_READ = 2'd0,
      ACT_LOAD = 2'd1,
      ACT_NEXT = 2'd2,
      ACT_PREV = 2'd3
   } action_type;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } div_status_type;

endpackage

>>> rtl/core/pst_channels.sv
interface pst_req_if import pst_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [ACTION_WIDTH-1:0] action;
   logic [FIELD_WIDTH-1:0]  load_value;

   modport source (output valid, action, load_value, input ready);
   modport sink   (input valid, action, load_value, output ready);
endinterface

interface pst_rsp_if import pst_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] value_before;
   logic [FIELD_WIDTH-1:0] value_after;
   logic                   overflow;

   modport source (output valid, value_before, value_after, overflow, input ready);
   modport sink   (input valid, value_before, value_after, overflow, output ready);
endinterface

>>> rtl/core/pst_divider.sv
module pst_divider import pst_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [VALUE_WIDTH-1:0] divisor,
   output div_status_type         status
);

   localparam int CNT_W = $clog2(VALUE_WIDTH);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] dvd_ff, dvd_in;
   logic [VALUE_WIDTH-1:0] dsr_ff, dsr_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH:0]   trial;

   // restoring remainder, one dividend bit per cycle, MSB first
   always_comb begin
      trial   = {rem_ff, dvd_ff[VALUE_WIDTH-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(VALUE_WIDTH - 1);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = VALUE_WIDTH'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = VALUE_WIDTH'(trial);
         end
         dvd_in = {dvd_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

>>> rtl/core/prime_stepper_trial_division.sv
// Read and load: the result is valid in the cycle after the command is accepted.
// Steps: each candidate is tried against trial divisors (2, then odd d while
// d*d <= candidate) on the bit-serial remainder unit, and a final square check
// accepts a prime.
// One command at a time: the next is taken the cycle after the result is taken.
// Synchronous active-high reset; the held value resets to 1.
module prime_stepper_trial_division import pst_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   pst_req_if.sink  req_ch,
   pst_rsp_if.source rsp_ch
);

   localparam int SQ_W = VALUE_WIDTH + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_CHECK,
      ST_DIV,
      ST_RESP
   } state_type;

   state_type              state_ff, state_in;
   action_type             act_ff, act_in;
   logic [VALUE_WIDTH-1:0] cur_ff, cur_in;
   logic [VALUE_WIDTH-1:0] before_ff, before_in;
   logic [VALUE_WIDTH-1:0] after_ff, after_in;
   logic                   ovf_ff, ovf_in;
   logic [VALUE_WIDTH-1:0] cand_ff, cand_in;
   logic [VALUE_WIDTH-1:0] d_ff, d_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic                   start_ff, start_in;
   logic                   reject;
   div_status_type         div_status;

   pst_divider #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (cand_ff),
      .divisor  (d_ff),
      .status   (div_status)
   );

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      cur_in    = cur_ff;
      before_in = before_ff;
      after_in  = after_ff;
      ovf_in    = ovf_ff;
      cand_in   = cand_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      start_in  = 1'b0;
      reject    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               act_in    = action_type'(req_ch.action);
               before_in = cur_ff;
               after_in  = cur_ff;
               ovf_in    = 1'b0;
               case (action_type'(req_ch.action))
                  ACT_READ: begin
                     state_in = ST_RESP;
                  end
                  ACT_LOAD: begin
                     after_in = VALUE_WIDTH'(req_ch.load_value);
                     cur_in   = VALUE_WIDTH'(req_ch.load_value);
                     state_in = ST_RESP;
                  end
                  ACT_NEXT: begin
                     if (cur_ff == '1) begin
                        ovf_in   = 1'b1;
                        state_in = ST_RESP;
                     end else begin
                        cand_in  = cur_ff + VALUE_WIDTH'(1);
                        state_in = ST_CAND;
                     end
                  end
                  ACT_PREV: begin
                     if (cur_ff < VALUE_WIDTH'(3)) begin
                        after_in = VALUE_WIDTH'(1);
                        cur_in   = VALUE_WIDTH'(1);
                        state_in = ST_RESP;
                     end else begin
                        cand_in  = cur_ff - VALUE_WIDTH'(1);
                        state_in = ST_CAND;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_CAND: begin
            if (cand_ff < VALUE_WIDTH'(2)) begin
               reject = 1'b1;
            end else begin
               d_in     = VALUE_WIDTH'(2);
               sq_in    = SQ_W'(4);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sq_ff > {2'b00, cand_ff}) begin
               after_in = cand_ff;
               cur_in   = cand_ff;
               state_in = ST_RESP;
            end else begin
               start_in = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               if (div_status.rem_zero) begin
                  reject = 1'b1;
               end else begin
                  // after 2 try odd divisors only; (d+2)^2 = d^2 + 4d + 4
                  if (d_ff == VALUE_WIDTH'(2)) begin
                     d_in  = VALUE_WIDTH'(3);
                     sq_in = SQ_W'(9);
                  end else begin
                     d_in  = d_ff + VALUE_WIDTH'(2);
                     sq_in = sq_ff + {d_ff, 2'b00} + SQ_W'(4);
                  end
                  state_in = ST_CHECK;
               end
            end
         end
         ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // candidate is not prime: advance or give up
      if (reject) begin
         if (act_ff == ACT_NEXT) begin
            if (cand_ff == '1) begin
               ovf_in   = 1'b1;
               state_in = ST_RESP;
            end else begin
               cand_in  = cand_ff + VALUE_WIDTH'(1);
               state_in = ST_CAND;
            end
         end else begin
            if (cand_ff <= VALUE_WIDTH'(2)) begin
               after_in = VALUE_WIDTH'(1);
               cur_in   = VALUE_WIDTH'(1);
               state_in = ST_RESP;
            end else begin
               cand_in  = cand_ff - VALUE_WIDTH'(1);
               state_in = ST_CAND;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff   <= VALUE_WIDTH'(1);
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         start_ff <= start_in;
      end
      act_ff    <= act_in;
      before_ff <= before_in;
      after_ff  <= after_in;
      ovf_ff    <= ovf_in;
      cand_ff   <= cand_in;
      d_ff      <= d_in;
      sq_ff     <= sq_in;
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = (state_ff == ST_RESP);
   assign rsp_ch.value_before = FIELD_WIDTH'(before_ff);
   assign rsp_ch.value_after  = FIELD_WIDTH'(after_ff);
   assign rsp_ch.overflow     = ovf_ff;

endmodule

>>> rtl/core/pst_checker.sv
`include "prime_stepper_trial_division_assert.svh"

module pst_checker import pst_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [FIELD_WIDTH-1:0] value_before,
   input logic [FIELD_WIDTH-1:0] value_after,
   input logic                   overflow
);

   `PST_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   `PST_ASSERT_IMP(a_one_in_flight, clock, reset, rsp_valid, !req_ready, "ready with result pending")
   `PST_ASSERT_IMP(a_overflow_keeps, clock, reset, rsp_valid && overflow, value_before == value_after, "overflow changed value")
   `PST_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(value_before) && $stable(value_after) && $stable(overflow), "stalled beat changed")

endmodule

bind prime_stepper_trial_division pst_checker u_pst_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .value_before (rsp_ch.value_before),
   .value_after  (rsp_ch.value_after),
   .overflow     (rsp_ch.overflow)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import pst_pkg::*;

   localparam int          VW          = VALUE_WIDTH_DEFAULT;
   localparam int unsigned VALUE_TOP   = (1 << VW) - 1;
   localparam int          STALL_LIMIT = 400000;
   localparam int          DRAIN       = 200;

   typedef struct {
      action_type             action;
      logic [FIELD_WIDTH-1:0] load_value;
   } command_t;

   typedef struct {
      logic [FIELD_WIDTH-1:0] value_before;
      logic [FIELD_WIDTH-1:0] value_after;
      logic                   overflow;
   } step_outcome_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pst_req_if req_ch ();
   pst_rsp_if rsp_ch ();

   prime_stepper_trial_division dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   command_t          pending_cmds[$];
   step_outcome_t     awaited_outcomes[$];
   command_t          next_cmd;
   logic [VW-1:0]     held_value;
   logic              req_beat_taken;
   int                cmds_accepted;
   int                mismatch_count;
   int                stall_cycles;
   int                idle_pct;

   always #10 clock = ~clock;

   function automatic bit is_prime_num(input int unsigned n);
      int unsigned d;
      if (n < 2) return 1'b0;
      for (d = 2; d * d <= n; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic step_outcome_t apply_command(input logic [VW-1:0] held,
                                                   input command_t cmd);
      step_outcome_t res;
      int unsigned   cand;
      bit            found;
      res.value_before = held;
      res.value_after  = held;
      res.overflow     = 1'b0;
      found            = 1'b0;
      case (cmd.action)
         ACT_LOAD: begin
            res.value_after = cmd.load_value[VW-1:0];
         end
         ACT_NEXT: begin
            cand = int'(held) + 1;
            while (cand <= VALUE_TOP && !found) begin
               if (is_prime_num(cand)) begin
                  found = 1'b1;
                  res.value_after = cand[VW-1:0];
               end
               cand++;
            end
            // keep the value when nothing fits the width
            if (!found) res.overflow = 1'b1;
         end
         ACT_PREV: begin
            res.value_after = 1;
            if (held >= 3) begin
               cand = int'(held) - 1;
               while (cand >= 2 && !found) begin
                  if (is_prime_num(cand)) begin
                     found = 1'b1;
                     res.value_after = cand[VW-1:0];
                  end
                  cand--;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic command_t make_cmd(input action_type act,
                                         input logic [FIELD_WIDTH-1:0] val);
      command_t c;
      c.action     = act;
      c.load_value = val;
      return c;
   endfunction

   function automatic command_t random_cmd();
      command_t    c;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15)      c.action = ACT_READ;
      else if (pick < 35) c.action = ACT_LOAD;
      else if (pick < 70) c.action = ACT_NEXT;
      else                c.action = ACT_PREV;
      pick = $urandom_range(99);
      if (c.action != ACT_LOAD) c.load_value = $urandom_range(65535);
      else if (pick < 80)       c.load_value = $urandom_range(1500);
      else if (pick < 92)       c.load_value = $urandom_range(65535);
      else                      c.load_value = $urandom_range(65535, 65400);
      return c;
   endfunction

   // Accept side: predict on each request beat.
   always @(posedge clock) begin
      if (reset) begin
         held_value     <= 1;
         req_beat_taken <= 1'b0;
         cmds_accepted  <= 0;
      end else begin
         req_beat_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            step_outcome_t exp_res;
            exp_res = apply_command(held_value,
                                    make_cmd(action_type'(req_ch.action), req_ch.load_value));
            awaited_outcomes.push_back(exp_res);
            held_value    <= exp_res.value_after;
            cmds_accepted <= cmds_accepted + 1;
         end
      end
   end

   // Driver: present a new beat once the current one is taken.
   always @(negedge clock) begin
      if (!reset) begin
         idle_pct = (cmds_accepted >= 45 && cmds_accepted < 75) ? 0 : 19;
         if (!req_ch.valid || req_beat_taken) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
               next_cmd = pending_cmds.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.action     <= next_cmd.action;
               req_ch.load_value <= next_cmd.load_value;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Monitor: compare each result beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_outcomes.size() == 0) begin
            $display("%0t: unexpected result before=%h after=%h overflow=%b", $time,
                     rsp_ch.value_before, rsp_ch.value_after, rsp_ch.overflow);
            mismatch_count++;
         end else begin
            step_outcome_t exp_res;
            exp_res = awaited_outcomes.pop_front();
            if (rsp_ch.value_before !== exp_res.value_before) begin
               $display("%0t: value_before expected %h actual %h", $time,
                        exp_res.value_before, rsp_ch.value_before);
               mismatch_count++;
            end
            if (rsp_ch.value_after !== exp_res.value_after) begin
               $display("%0t: value_after expected %h actual %h", $time,
                        exp_res.value_after, rsp_ch.value_after);
               mismatch_count++;
            end
            if (rsp_ch.overflow !== exp_res.overflow) begin
               $display("%0t: overflow expected %b actual %b", $time,
                        exp_res.overflow, rsp_ch.overflow);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: give up after a long stretch with no beat on either side.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, stall_cycles);
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.action     = ACT_READ;
      req_ch.load_value = '0;
      rsp_ch.ready      = 1'b0;
      mismatch_count    = 0;
      stall_cycles      = 0;
      idle_pct          = 19;

      // Out of reset, steps around the bottom of the range.
      pending_cmds.push_back(make_cmd(ACT_READ, 16'h0000));
      pending_cmds.push_back(make_cmd(ACT_PREV, 16'hffff));
      pending_cmds.push_back(make_cmd(ACT_NEXT, 16'h0000));
      pending_cmds.push_back(make_cmd(ACT_PREV, 16'hffff));
      pending_cmds.push_back(make_cmd(ACT_LOAD, 16'h0000));
      pending_cmds.push_back(make_cmd(ACT_READ, 16'hffff));
      pending_cmds.push_back(make_cmd(ACT_NEXT, 16'h0000));
      pending_cmds.push_back(make_cmd(ACT_NEXT, 16'h0000));
      pending_cmds.push_back(make_cmd(ACT_PREV, 16'h0000));
      pending_cmds.push_back(make_cmd(ACT_LOAD, 16'h0000));
      pending_cmds.push_back(make_cmd(ACT_PREV, 16'hffff));
      // Top of the range: no prime above, largest prime below.
      pending_cmds.push_back(make_cmd(ACT_LOAD, 16'hffff));
      pending_cmds.push_back(make_cmd(ACT_NEXT, 16'h0000));
      pending_cmds.push_back(make_cmd(ACT_PREV, 16'h0000));
      pending_cmds.push_back(make_cmd(ACT_NEXT, 16'hffff));
      pending_cmds.push_back(make_cmd(ACT_LOAD, 16'd65520));
      pending_cmds.push_back(make_cmd(ACT_NEXT, 16'h0000));
      // Widest prime gap in range.
      pending_cmds.push_back(make_cmd(ACT_LOAD, 16'd31398));
      pending_cmds.push_back(make_cmd(ACT_NEXT, 16'h0000));
      pending_cmds.push_back(make_cmd(ACT_PREV, 16'h0000));
      pending_cmds.push_back(make_cmd(ACT_LOAD, 16'd24));
      pending_cmds.push_back(make_cmd(ACT_PREV, 16'h5555));
      pending_cmds.push_back(make_cmd(ACT_NEXT, 16'haaaa));
      repeat (77) pending_cmds.push_back(random_cmd());

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_cmds.size() != 0 || req_ch.valid || awaited_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
